// File: rtl/mmvs_pkg.sv
// Package for the masked mean, variance and standard deviation core.
// Holds the width constants, step counts and the command and status structs.
// Used by mmvs_ctrl, mmvs_datapath and masked_mean_variance_stddev_core.
`default_nettype none

package mmvs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 20;
  localparam int SUM_W      = SAMPLE_W + COUNT_W;
  localparam int SQ_W       = 2 * SAMPLE_W + COUNT_W - 1;
  localparam int VAR_W      = 2 * SAMPLE_W - 1;
  localparam int MAG_W      = SUM_W - 1;
  localparam int PROD_W     = SQ_W + COUNT_W;
  localparam int NN_W       = 2 * COUNT_W;
  localparam int RAD_W      = 2 * SAMPLE_W;
  localparam int ROOT_REM_W = SAMPLE_W + 2;
  localparam int MAX_STEPS  = (VAR_W > MAG_W) ? VAR_W : MAG_W;
  localparam int STEP_W     = $clog2(MAX_STEPS);

  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] MEAN_LAST = STEP_W'(SAMPLE_W - 1);
  localparam logic [STEP_W-1:0] VAR_LAST  = STEP_W'(VAR_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(SAMPLE_W - 1);

  typedef enum logic [1:0] {
    MUL_NS,
    MUL_SS,
    MUL_NN
  } mul_sel_t;

  typedef enum logic {
    DIV_MEAN,
    DIV_VAR
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     save_ns;
    logic     save_num;
    logic     save_nn;
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     save_mean;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     out_load;
  } mmvs_cmd_t;

  typedef struct packed {
    logic empty;
    logic out_free;
  } mmvs_stat_t;

endpackage

`default_nettype wire

// File: rtl/mmvs_ctrl.sv
// Controller state machine for the masked mean, variance and deviation core.
// Sequences accumulation, the shared multiplier, divider and square root.
// Depends on mmvs_pkg.
`default_nettype none

module mmvs_ctrl
  import mmvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       last,
  output logic       in_ready,
  input  mmvs_stat_t stat,
  output mmvs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_CHECK,
    ST_NS_LOAD,
    ST_NS_RUN,
    ST_SS_LOAD,
    ST_SS_RUN,
    ST_NN_LOAD,
    ST_NN_RUN,
    ST_MEAN_LOAD,
    ST_MEAN_RUN,
    ST_VAR_LOAD,
    ST_VAR_RUN,
    ST_ROOT_LOAD,
    ST_ROOT_RUN,
    ST_OUT_WAIT
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  assign in_ready = (state == ST_ACCUM);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_ACCUM: begin
        cmd.accept = in_valid;
        if (in_valid && last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.empty ? ST_OUT_WAIT : ST_NS_LOAD;
      end
      ST_NS_LOAD: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_NS;
        cnt_next     = '0;
        state_next   = ST_NS_RUN;
      end
      ST_NS_RUN: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = ST_SS_LOAD;
        end
      end
      ST_SS_LOAD: begin
        cmd.save_ns  = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_SS;
        cnt_next     = '0;
        state_next   = ST_SS_RUN;
      end
      ST_SS_RUN: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = ST_NN_LOAD;
        end
      end
      ST_NN_LOAD: begin
        cmd.save_num = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_NN;
        cnt_next     = '0;
        state_next   = ST_NN_RUN;
      end
      ST_NN_RUN: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = ST_MEAN_LOAD;
        end
      end
      ST_MEAN_LOAD: begin
        cmd.save_nn  = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_MEAN;
        cnt_next     = '0;
        state_next   = ST_MEAN_RUN;
      end
      ST_MEAN_RUN: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MEAN_LAST) begin
          state_next = ST_VAR_LOAD;
        end
      end
      ST_VAR_LOAD: begin
        cmd.save_mean = 1'b1;
        cmd.div_load  = 1'b1;
        cmd.div_sel   = DIV_VAR;
        cnt_next      = '0;
        state_next    = ST_VAR_RUN;
      end
      ST_VAR_RUN: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == VAR_LAST) begin
          state_next = ST_ROOT_LOAD;
        end
      end
      ST_ROOT_LOAD: begin
        cmd.sqrt_load = 1'b1;
        cnt_next      = '0;
        state_next    = ST_ROOT_RUN;
      end
      ST_ROOT_RUN: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == ROOT_LAST) begin
          state_next = ST_OUT_WAIT;
        end
      end
      ST_OUT_WAIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mmvs_datapath.sv
// Datapath for the masked mean, variance and deviation core: square stage,
// accumulators, shift-add multiplier, restoring divider, square root, output.
// Depends on mmvs_pkg; driven by mmvs_ctrl through mmvs_cmd_t.
`default_nettype none

module mmvs_datapath
  import mmvs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  mmvs_cmd_t                  cmd,
  output mmvs_stat_t                 stat,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       sample_valid,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COUNT_W-1:0]         valid_count,
  output logic signed [SUM_W-1:0]    total,
  output logic [SQ_W-1:0]            total_squares,
  output logic signed [SAMPLE_W-1:0] set_mean,
  output logic [VAR_W-1:0]           pop_variance,
  output logic [SAMPLE_W-1:0]        std_dev,
  output logic                       empty_set,
  output logic                       count_overflow
);

  logic                         s1_full;
  logic                         s1_valid;
  logic signed [SAMPLE_W-1:0]   s1_sample;
  logic [VAR_W-1:0]             s1_square;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  logic [COUNT_W-1:0]           count;
  logic signed [SUM_W-1:0]      sum;
  logic [SQ_W-1:0]              sumsq;
  logic                         overflow;
  logic [SUM_W-1:0]             sum_neg;
  logic [MAG_W-1:0]             mag;

  logic [PROD_W-1:0]            mul_a;
  logic [MAG_W-1:0]             mul_b;
  logic [PROD_W-1:0]            mul_p;
  logic [PROD_W-1:0]            num;
  logic [NN_W-1:0]              nn;

  logic [NN_W-1:0]              div_rem;
  logic [NN_W-1:0]              div_d;
  logic [VAR_W-1:0]             div_dq;
  logic [NN_W:0]                div_rem2;
  logic [NN_W:0]                div_diff;
  logic                         div_ge;
  logic [SAMPLE_W-1:0]          mean_q;
  logic [SAMPLE_W-1:0]          mean;

  logic [RAD_W-1:0]             rt_v;
  logic [ROOT_REM_W-1:0]        rt_rem;
  logic [SAMPLE_W-1:0]          rt_root;
  logic [ROOT_REM_W+1:0]        rt_rem2;
  logic [ROOT_REM_W+1:0]        rt_trial;
  logic [ROOT_REM_W+1:0]        rt_diff;
  logic                         rt_ge;

  assign sq_full = sample * sample;
  assign sum_neg = -sum;
  assign mag     = sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];

  assign stat.empty    = (count == '0);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
    end else begin
      s1_full <= cmd.accept;
    end
    if (cmd.accept) begin
      s1_valid  <= sample_valid;
      s1_sample <= sample;
      s1_square <= sq_full[VAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      count    <= '0;
      sum      <= '0;
      sumsq    <= '0;
      overflow <= 1'b0;
    end else if (s1_full && s1_valid) begin
      if (count == {COUNT_W{1'b1}}) begin
        overflow <= 1'b1;
      end else begin
        count <= count + 1'b1;
        sum   <= sum + {{(SUM_W-SAMPLE_W){s1_sample[SAMPLE_W-1]}}, s1_sample};
        sumsq <= sumsq + SQ_W'(s1_square);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_p <= '0;
      unique case (cmd.mul_sel)
        MUL_NS: begin
          mul_a <= PROD_W'(sumsq);
          mul_b <= MAG_W'(count);
        end
        MUL_SS: begin
          mul_a <= PROD_W'(mag);
          mul_b <= mag;
        end
        MUL_NN: begin
          mul_a <= PROD_W'(count);
          mul_b <= MAG_W'(count);
        end
        default: begin
          mul_a <= '0;
          mul_b <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      if (mul_b[0]) begin
        mul_p <= mul_p + mul_a;
      end
      mul_a <= {mul_a[PROD_W-2:0], 1'b0};
      mul_b <= {1'b0, mul_b[MAG_W-1:1]};
    end
    if (cmd.save_ns) begin
      num <= mul_p;
    end else if (cmd.save_num) begin
      num <= num - mul_p;
    end
    if (cmd.save_nn) begin
      nn <= mul_p[NN_W-1:0];
    end
  end

  assign div_rem2 = {div_rem, div_dq[VAR_W-1]};
  assign div_diff = div_rem2 - {1'b0, div_d};
  assign div_ge   = (div_rem2 >= {1'b0, div_d});
  assign mean_q   = div_dq[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      unique case (cmd.div_sel)
        DIV_MEAN: begin
          div_rem <= NN_W'(mag[MAG_W-1:SAMPLE_W]);
          div_dq  <= {mag[SAMPLE_W-1:0], {(VAR_W-SAMPLE_W){1'b0}}};
          div_d   <= NN_W'(count);
        end
        DIV_VAR: begin
          div_rem <= num[PROD_W-1:VAR_W];
          div_dq  <= num[VAR_W-1:0];
          div_d   <= nn;
        end
      endcase
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? div_diff[NN_W-1:0] : div_rem2[NN_W-1:0];
      div_dq  <= {div_dq[VAR_W-2:0], div_ge};
    end
    if (cmd.save_mean) begin
      mean <= sum[SUM_W-1] ? -mean_q : mean_q;
    end
  end

  assign rt_rem2  = {rt_rem, rt_v[RAD_W-1:RAD_W-2]};
  assign rt_trial = (ROOT_REM_W+2)'({rt_root, 2'b01});
  assign rt_diff  = rt_rem2 - rt_trial;
  assign rt_ge    = (rt_rem2 >= rt_trial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      rt_v    <= RAD_W'(div_dq);
      rt_rem  <= '0;
      rt_root <= '0;
    end else if (cmd.sqrt_step) begin
      rt_v    <= {rt_v[RAD_W-3:0], 2'b00};
      rt_rem  <= rt_ge ? rt_diff[ROOT_REM_W-1:0] : rt_rem2[ROOT_REM_W-1:0];
      rt_root <= {rt_root[SAMPLE_W-2:0], rt_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      valid_count    <= count;
      total          <= sum;
      total_squares  <= sumsq;
      count_overflow <= overflow;
      empty_set      <= stat.empty;
      if (stat.empty) begin
        set_mean     <= '0;
        pop_variance <= '0;
        std_dev      <= '0;
      end else begin
        set_mean     <= mean;
        pop_variance <= div_dq;
        std_dev      <= rt_root;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/masked_mean_variance_stddev_core.sv
// Top level of the masked mean, variance and standard deviation core.
// Joins the controller mmvs_ctrl and the datapath mmvs_datapath; uses mmvs_pkg.
//
// Channel  Handshake            Payload
// in       in_valid, in_ready   sample, sample_valid, last
// out      out_valid, out_ready valid_count, total, total_squares, set_mean,
//                               pop_variance, std_dev, empty_set, count_overflow
//
// Samples are taken one per cycle while a set accumulates.
// After the last request of a set the core computes the result in turn:
// three 35-step shift-add products, a 16-step and a 31-step
// restoring divide and a 16-step square root; an empty set skips these steps.
// Reset clears the control state, the square-stage flag, the accumulators and out_valid; nothing else is swept.
// A result waits in the output register while the next set accumulates; a
// set that finishes while that result is still untaken waits for it.
`default_nettype none

module masked_mean_variance_stddev_core
  import mmvs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       sample_valid,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COUNT_W-1:0]         valid_count,
  output logic signed [SUM_W-1:0]    total,
  output logic [SQ_W-1:0]            total_squares,
  output logic signed [SAMPLE_W-1:0] set_mean,
  output logic [VAR_W-1:0]           pop_variance,
  output logic [SAMPLE_W-1:0]        std_dev,
  output logic                       empty_set,
  output logic                       count_overflow
);

  mmvs_cmd_t  cmd;
  mmvs_stat_t stat;

  mmvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmvs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .sample         (sample),
    .sample_valid   (sample_valid),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .valid_count    (valid_count),
    .total          (total),
    .total_squares  (total_squares),
    .set_mean       (set_mean),
    .pop_variance   (pop_variance),
    .std_dev        (std_dev),
    .empty_set      (empty_set),
    .count_overflow (count_overflow)
  );

endmodule

`default_nettype wire
